/* hdl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver core.
// ----------------------------------------------------------------------------
package qrs_pkg;

   // coefficient format and derived datapath widths
   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS     = 16;
   localparam int EPS_BITS      = 16;
   localparam int DEN_BITS      = WORD_BITS + 1;
   localparam int PROD_BITS     = 2 * WORD_BITS;
   localparam int DISC_BITS     = PROD_BITS + 1;
   localparam int ROOT_BITS     = (DISC_BITS + 1) / 2;
   localparam int RAD_BITS      = 2 * ROOT_BITS;
   localparam int NUM_BITS      = ROOT_BITS + 1;
   localparam int DVD_BITS      = NUM_BITS + FRAC_BITS;

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EPSILON = 3'd0;
   localparam logic [EPS_BITS-1:0] EPSILON_RESET = 16'd1;

   // root count codes
   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_TWO  = 2'd2;
   localparam logic [1:0] COUNT_INF  = 2'd3;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] coef_a;
      logic signed [WORD_BITS-1:0] coef_b;
      logic signed [WORD_BITS-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic [1:0]                  root_count;
      logic signed [WORD_BITS-1:0] root_low;
      logic signed [WORD_BITS-1:0] root_high;
      logic                        linear_case;
      logic                        saturated;
   } rsp_type;

   // item context that rides along the sqrt and divider pipes
   typedef struct packed {
      logic [1:0]           count;
      logic                 lin;
      logic                 mb_neg;
      logic [WORD_BITS-1:0] mb_mag;
      logic                 den_neg;
      logic [DEN_BITS-1:0]  den_mag;
   } side_type;

endpackage

/* hdl/qrs_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// Floor integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [qrs_pkg::RAD_BITS-1:0]     in_rad,
   input  qrs_pkg::side_type                in_side,
   output logic                             out_valid,
   output logic [qrs_pkg::ROOT_BITS-1:0]    out_root,
   output qrs_pkg::side_type                out_side
);

   localparam int ROOT_BITS = qrs_pkg::ROOT_BITS;
   localparam int RAD_BITS  = qrs_pkg::RAD_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;

   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
      qrs_pkg::side_type    side;
   } sq_stage_type;

   sq_stage_type         st_ff [0:ROOT_BITS];
   logic [ROOT_BITS:0]   valid_ff;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0].rad  <= in_rad;
         st_ff[0].rem  <= '0;
         st_ff[0].root <= '0;
         st_ff[0].side <= in_side;
      end
   end

   // one root bit per stage
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
      logic [REM_BITS+1:0] trial_rem;
      logic [REM_BITS+1:0] trial;
      logic                ge;
      sq_stage_type        st_in;

      always_comb begin
         trial_rem = {st_ff[k].rem, st_ff[k].rad[RAD_BITS-1 -: 2]};
         trial     = {2'b00, st_ff[k].root, 2'b01};
         ge        = (trial_rem >= trial);
         st_in.rad  = {st_ff[k].rad[RAD_BITS-3:0], 2'b00};
         st_in.rem  = ge ? REM_BITS'(trial_rem - trial) : trial_rem[REM_BITS-1:0];
         st_in.root = {st_ff[k].root[ROOT_BITS-2:0], ge};
         st_in.side = st_ff[k].side;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k+1] <= st_in;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS];
   assign out_root  = st_ff[ROOT_BITS].root;
   assign out_side  = st_ff[ROOT_BITS].side;

endmodule

/* hdl/qrs_div_pipe.sv */
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Signed fixed-point divide (n << FRAC_BITS) / d, one quotient bit per
// stage, truncated toward zero and clamped to the word range.
// ----------------------------------------------------------------------------
module qrs_div_pipe (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic                                  in_nneg,
   input  logic [qrs_pkg::NUM_BITS-1:0]          in_nmag,
   input  logic                                  in_dneg,
   input  logic [qrs_pkg::DEN_BITS-1:0]          in_dmag,
   input  qrs_pkg::side_type                     in_side,
   output logic                                  out_valid,
   output logic signed [qrs_pkg::WORD_BITS-1:0]  out_root,
   output logic                                  out_sat,
   output qrs_pkg::side_type                     out_side
);

   localparam int DVD_BITS  = qrs_pkg::DVD_BITS;
   localparam int DEN_BITS  = qrs_pkg::DEN_BITS;
   localparam int WORD_BITS = qrs_pkg::WORD_BITS;
   localparam int FRAC_BITS = qrs_pkg::FRAC_BITS;

   localparam logic [DVD_BITS-1:0] POS_LIMIT =
      {{(DVD_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic [DVD_BITS-1:0] NEG_LIMIT = POS_LIMIT + 1'b1;
   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic [DVD_BITS-1:0] dvd;
      logic [DEN_BITS-1:0] rem;
      logic [DEN_BITS-1:0] dmag;
      logic                neg;
      logic                nneg;
      logic                nzero;
      logic                dzero;
      qrs_pkg::side_type   side;
   } dv_stage_type;

   dv_stage_type        st_ff [0:DVD_BITS];
   logic [DVD_BITS:0]   valid_ff;
   logic                out_valid_ff;
   logic [WORD_BITS-1:0] root_ff;
   logic                sat_ff;
   qrs_pkg::side_type   side_ff;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0].dvd   <= {in_nmag, {FRAC_BITS{1'b0}}};
         st_ff[0].rem   <= '0;
         st_ff[0].dmag  <= in_dmag;
         st_ff[0].neg   <= in_nneg ^ in_dneg;
         st_ff[0].nneg  <= in_nneg;
         st_ff[0].nzero <= (in_nmag == '0);
         st_ff[0].dzero <= (in_dmag == '0);
         st_ff[0].side  <= in_side;
      end
   end

   // restoring divide step, the dividend word collects the quotient bits
   for (genvar k = 0; k < DVD_BITS; k++) begin : g_step
      logic [DEN_BITS:0] cand;
      logic              ge;
      dv_stage_type      st_in;

      always_comb begin
         cand  = {st_ff[k].rem, st_ff[k].dvd[DVD_BITS-1]};
         ge    = (cand >= {1'b0, st_ff[k].dmag});
         st_in = st_ff[k];
         st_in.rem = ge ? DEN_BITS'(cand - {1'b0, st_ff[k].dmag}) : cand[DEN_BITS-1:0];
         st_in.dvd = {st_ff[k].dvd[DVD_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k+1] <= st_in;
         end
      end
   end

   // sign and clamp
   logic [DVD_BITS-1:0]  quot;
   logic [WORD_BITS-1:0] root_in;
   logic                 sat_in;

   always_comb begin
      quot    = st_ff[DVD_BITS].dvd;
      root_in = '0;
      sat_in  = 1'b0;
      priority if (st_ff[DVD_BITS].nzero) begin
         root_in = '0;
      end else if (st_ff[DVD_BITS].dzero) begin
         sat_in  = 1'b1;
         root_in = st_ff[DVD_BITS].nneg ? WORD_MIN : WORD_MAX;
      end else if (st_ff[DVD_BITS].neg) begin
         if (quot > NEG_LIMIT) begin
            sat_in  = 1'b1;
            root_in = WORD_MIN;
         end else begin
            root_in = -quot[WORD_BITS-1:0];
         end
      end else begin
         if (quot > POS_LIMIT) begin
            sat_in  = 1'b1;
            root_in = WORD_MAX;
         end else begin
            root_in = quot[WORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[DVD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in;
         sat_ff  <= sat_in;
         side_ff <= st_ff[DVD_BITS].side;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_root  = root_ff;
   assign out_sat   = sat_ff;
   assign out_side  = side_ff;

endmodule

/* hdl/quadratic_root_solver_core.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Roots of a*x^2 + b*x + c = 0 for signed Q16.16 coefficients.
// ----------------------------------------------------------------------------
// Takes one coefficient item per cycle while not stalled and returns one
// result item per input item, in order, through the square root (one root
// bit per stage, 34 stages) and the divider (one quotient bit per stage, 52
// stages); four stages of unpack, multiply, discriminant and classify come
// first, two stages form the numerators between them, and one stage sorts
// the roots. A stall on the result channel holds the whole pipeline and is
// passed back to req_stall. The user must write epsilon through the register
// port only while no item is in flight; the core does not enforce this.
module quadratic_root_solver_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  qrs_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output qrs_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [qrs_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [qrs_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [qrs_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   localparam int WORD_BITS = qrs_pkg::WORD_BITS;
   localparam int FRAC_BITS = qrs_pkg::FRAC_BITS;
   localparam int EPS_BITS  = qrs_pkg::EPS_BITS;
   localparam int DEN_BITS  = qrs_pkg::DEN_BITS;
   localparam int PROD_BITS = qrs_pkg::PROD_BITS;
   localparam int DISC_BITS = qrs_pkg::DISC_BITS;
   localparam int ROOT_BITS = qrs_pkg::ROOT_BITS;
   localparam int RAD_BITS  = qrs_pkg::RAD_BITS;
   localparam int NUM_BITS  = qrs_pkg::NUM_BITS;

   typedef struct packed {
      logic                 an;
      logic                 bn;
      logic                 cn;
      logic [WORD_BITS-1:0] am;
      logic [WORD_BITS-1:0] bm;
      logic [WORD_BITS-1:0] cm;
   } coef_type;

   logic en;
   logic [EPS_BITS-1:0] eps_ff;

   // whole pipe advances unless the result register is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = rsp_valid && rsp_stall;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == qrs_pkg::CSR_EPSILON) ?
                       qrs_pkg::CSR_DATA_BITS'(eps_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= qrs_pkg::EPSILON_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == qrs_pkg::CSR_EPSILON) begin
         eps_ff <= csr_pwdata[EPS_BITS-1:0];
      end
   end

   // stage a: sign and magnitude of each coefficient
   logic     a_valid_ff;
   coef_type a_ff, a_in;

   always_comb begin
      a_in.an = req_data.coef_a[WORD_BITS-1];
      a_in.bn = req_data.coef_b[WORD_BITS-1];
      a_in.cn = req_data.coef_c[WORD_BITS-1];
      a_in.am = a_in.an ? -req_data.coef_a : req_data.coef_a;
      a_in.bm = a_in.bn ? -req_data.coef_b : req_data.coef_b;
      a_in.cm = a_in.cn ? -req_data.coef_c : req_data.coef_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
      end
   end

   // stage b: products and the zero tests
   logic                 b_valid_ff;
   coef_type             b_ff;
   logic [PROD_BITS-1:0] bb_ff;
   logic [PROD_BITS-1:0] ac_ff;
   logic                 lin_ff, b_big_ff, c_small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff       <= a_ff;
         bb_ff      <= PROD_BITS'(a_ff.bm * a_ff.bm);
         ac_ff      <= PROD_BITS'(a_ff.am * a_ff.cm);
         lin_ff     <= a_ff.am < WORD_BITS'(eps_ff);
         b_big_ff   <= a_ff.bm > WORD_BITS'(eps_ff);
         c_small_ff <= a_ff.cm < WORD_BITS'(eps_ff);
      end
   end

   // stage c: discriminant magnitude and sign
   logic                 c_valid_ff;
   coef_type             c_ff;
   logic                 c_lin_ff, c_b_big_ff, c_c_small_ff;
   logic [DISC_BITS-1:0] dmag_ff, dmag_in;
   logic                 dneg_ff, dneg_in;
   logic [DISC_BITS-1:0] bb_ext, ac4;

   always_comb begin
      bb_ext  = DISC_BITS'(bb_ff);
      ac4     = {ac_ff, 1'b0};
      ac4     = {ac4[DISC_BITS-2:0], 1'b0};
      dneg_in = 1'b0;
      priority if (b_ff.an != b_ff.cn) begin
         dmag_in = bb_ext + ac4;
      end else if (bb_ext >= ac4) begin
         dmag_in = bb_ext - ac4;
      end else begin
         dmag_in = ac4 - bb_ext;
         dneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff         <= b_ff;
         c_lin_ff     <= lin_ff;
         c_b_big_ff   <= b_big_ff;
         c_c_small_ff <= c_small_ff;
         dmag_ff      <= dmag_in;
         dneg_ff      <= dneg_in;
      end
   end

   // stage d: classify, pick numerator, divisor and radicand
   logic                d_valid_ff;
   qrs_pkg::side_type   d_side_ff, d_side_in;
   logic [RAD_BITS-1:0] d_rad_ff, d_rad_in;
   logic [DISC_BITS-1:0] thr;

   always_comb begin
      thr               = DISC_BITS'(eps_ff) << FRAC_BITS;
      d_rad_in          = '0;
      d_side_in.lin     = c_lin_ff;
      d_side_in.count   = qrs_pkg::COUNT_NONE;
      d_side_in.mb_neg  = 1'b0;
      d_side_in.mb_mag  = '0;
      d_side_in.den_neg = c_ff.an;
      d_side_in.den_mag = {c_ff.am, 1'b0};
      if (c_lin_ff) begin
         d_side_in.den_neg = c_ff.bn;
         d_side_in.den_mag = DEN_BITS'(c_ff.bm);
         priority if (c_b_big_ff) begin
            d_side_in.count  = qrs_pkg::COUNT_ONE;
            d_side_in.mb_neg = !c_ff.cn;
            d_side_in.mb_mag = c_ff.cm;
         end else if (c_c_small_ff) begin
            d_side_in.count = qrs_pkg::COUNT_INF;
         end else begin
            d_side_in.count = qrs_pkg::COUNT_NONE;
         end
      end else begin
         d_side_in.mb_neg = !c_ff.bn;
         priority if (dneg_ff && dmag_ff > thr) begin
            d_side_in.count = qrs_pkg::COUNT_NONE;
         end else if (dmag_ff < thr) begin
            d_side_in.count  = qrs_pkg::COUNT_ONE;
            d_side_in.mb_mag = c_ff.bm;
         end else begin
            // discriminant exactly at minus epsilon takes a zero square root
            d_side_in.count  = qrs_pkg::COUNT_TWO;
            d_side_in.mb_mag = c_ff.bm;
            d_rad_in         = dneg_ff ? '0 : RAD_BITS'(dmag_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_side_ff <= d_side_in;
         d_rad_ff  <= d_rad_in;
      end
   end

   // square root
   logic                 sq_valid;
   logic [ROOT_BITS-1:0] sq_root;
   qrs_pkg::side_type    sq_side;

   qrs_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid_ff),
      .in_rad    (d_rad_ff),
      .in_side   (d_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage e: numerators -b + s and -b - s
   logic                       e_valid_ff;
   qrs_pkg::side_type          e_side_ff;
   logic signed [NUM_BITS:0]   n1_ff, n2_ff;
   logic signed [NUM_BITS:0]   mb_s, s_s;

   always_comb begin
      mb_s = sq_side.mb_neg ? -$signed((NUM_BITS+1)'(sq_side.mb_mag))
                            : $signed((NUM_BITS+1)'(sq_side.mb_mag));
      s_s  = $signed((NUM_BITS+1)'(sq_root));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_side_ff <= sq_side;
         n1_ff     <= mb_s + s_s;
         n2_ff     <= mb_s - s_s;
      end
   end

   // stage f: sign and magnitude of the numerators
   logic                f_valid_ff;
   qrs_pkg::side_type   f_side_ff;
   logic                n1_neg_ff, n2_neg_ff;
   logic [NUM_BITS-1:0] n1_mag_ff, n2_mag_ff;
   logic [NUM_BITS:0]   n1_abs, n2_abs;

   assign n1_abs = n1_ff[NUM_BITS] ? -n1_ff : n1_ff;
   assign n2_abs = n2_ff[NUM_BITS] ? -n2_ff : n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_side_ff <= e_side_ff;
         n1_neg_ff <= n1_ff[NUM_BITS];
         n2_neg_ff <= n2_ff[NUM_BITS];
         n1_mag_ff <= n1_abs[NUM_BITS-1:0];
         n2_mag_ff <= n2_abs[NUM_BITS-1:0];
      end
   end

   // two dividers side by side
   logic                         dv1_valid, dv2_valid;
   logic signed [WORD_BITS-1:0]  r1, r2;
   logic                         sat1, sat2;
   qrs_pkg::side_type            dv1_side, dv2_side;

   qrs_div_pipe u_div_one (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid_ff),
      .in_nneg   (n1_neg_ff),
      .in_nmag   (n1_mag_ff),
      .in_dneg   (f_side_ff.den_neg),
      .in_dmag   (f_side_ff.den_mag),
      .in_side   (f_side_ff),
      .out_valid (dv1_valid),
      .out_root  (r1),
      .out_sat   (sat1),
      .out_side  (dv1_side)
   );

   qrs_div_pipe u_div_two (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid_ff),
      .in_nneg   (n2_neg_ff),
      .in_nmag   (n2_mag_ff),
      .in_dneg   (f_side_ff.den_neg),
      .in_dmag   (f_side_ff.den_mag),
      .in_side   (f_side_ff),
      .out_valid (dv2_valid),
      .out_root  (r2),
      .out_sat   (sat2),
      .out_side  (dv2_side)
   );

   // result register: sort the two roots
   logic             rsp_valid_ff;
   qrs_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.root_count  = dv1_side.count;
      rsp_in.linear_case = dv1_side.lin;
      rsp_in.saturated   = sat1 || sat2;
      rsp_in.root_low    = (r1 < r2) ? r1 : r2;
      rsp_in.root_high   = (r1 < r2) ? r2 : r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv1_valid && dv2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // no-root and infinite-root items carry zero roots
   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.root_count == qrs_pkg::COUNT_NONE ||
                    rsp_data.root_count == qrs_pkg::COUNT_INF)
      |-> rsp_data.root_low == '0 && rsp_data.root_high == '0)
      else $error("nonzero root with no finite root count");

   // roots leave in ascending order
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.root_low <= rsp_data.root_high)
      else $error("roots not sorted");

   // a linear item never reports two roots
   a_linear_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.linear_case |-> rsp_data.root_count != qrs_pkg::COUNT_TWO)
      else $error("linear item with two roots");

   // both divider lanes stay in step
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      dv1_valid == dv2_valid && (!dv1_valid || dv1_side == dv2_side))
      else $error("divider lanes out of step");
`endif

endmodule

/* tb/quadratic_root_solver_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_checker
// Watches both channels, computes the expected roots and compares.
// ----------------------------------------------------------------------------
// Every coefficient item taken on the request side is solved here with exact
// wide integer arithmetic. The expected result is queued, and every result
// item is checked field by field against the oldest one in the queue.
module quadratic_root_solver_core_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  qrs_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  qrs_pkg::rsp_type             rsp_data,
   input  logic [qrs_pkg::EPS_BITS-1:0] epsilon,
   output int                           errors,
   output int                           pending,
   output int                           results_seen
);

   localparam int WORD_BITS = qrs_pkg::WORD_BITS;
   localparam int FRAC_BITS = qrs_pkg::FRAC_BITS;
   localparam int EPS_BITS  = qrs_pkg::EPS_BITS;

   localparam logic signed [WORD_BITS-1:0] ROOT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] ROOT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   qrs_pkg::rsp_type expected_roots[$];

   // signed quotient (num << FRAC_BITS) / den, truncated and clamped
   function automatic logic signed [WORD_BITS-1:0] scaled_quotient(
      input logic num_neg, input logic [127:0] num_mag,
      input logic den_neg, input logic [127:0] den_mag, inout logic sat);
      logic [127:0] q;
      logic signed [WORD_BITS-1:0] r;
      if (num_mag == 0) begin
         r = '0;
      end else if (den_mag == 0) begin
         sat = 1'b1;
         r = num_neg ? ROOT_MIN : ROOT_MAX;
      end else begin
         q = (num_mag << FRAC_BITS) / den_mag;
         if (num_neg != den_neg) begin
            if (q > 128'h8000_0000) begin
               sat = 1'b1;
               r = ROOT_MIN;
            end else begin
               r = -q[WORD_BITS-1:0];
            end
         end else if (q > 128'h7fff_ffff) begin
            sat = 1'b1;
            r = ROOT_MAX;
         end else begin
            r = q[WORD_BITS-1:0];
         end
      end
      return r;
   endfunction

   function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
      logic [127:0] r;
      logic [127:0] t;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (128'd1 << i);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic qrs_pkg::rsp_type solve_roots(input qrs_pkg::req_type c,
                                                    input logic [EPS_BITS-1:0] eps);
      qrs_pkg::rsp_type o;
      logic an, bn, cn, dneg, sat;
      logic [127:0] am, bm, cm, bb, ac, dmag, thr, s, m1, m2;
      logic signed [129:0] mb, n1, n2;
      logic signed [WORD_BITS-1:0] r1, r2;
      o = '0;
      sat = 1'b0;
      an = c.coef_a[WORD_BITS-1];
      bn = c.coef_b[WORD_BITS-1];
      cn = c.coef_c[WORD_BITS-1];
      am = an ? 128'(-{1'b1, c.coef_a}) & 128'hffff_ffff : 128'(c.coef_a) & 128'hffff_ffff;
      bm = bn ? 128'(-{1'b1, c.coef_b}) & 128'hffff_ffff : 128'(c.coef_b) & 128'hffff_ffff;
      cm = cn ? 128'(-{1'b1, c.coef_c}) & 128'hffff_ffff : 128'(c.coef_c) & 128'hffff_ffff;
      if (am < eps) begin
         o.linear_case = 1'b1;
         if (bm > eps) begin
            o.root_low = scaled_quotient(!cn, cm, bn, bm, sat);
            o.root_high = o.root_low;
            o.root_count = qrs_pkg::COUNT_ONE;
         end else if (cm < eps) begin
            o.root_count = qrs_pkg::COUNT_INF;
         end
      end else begin
         bb = bm * bm;
         ac = (am * cm) << 2;
         dneg = 1'b0;
         if (an != cn) dmag = bb + ac;
         else if (bb >= ac) dmag = bb - ac;
         else begin
            dmag = ac - bb;
            dneg = 1'b1;
         end
         thr = 128'(eps) << FRAC_BITS;
         if (dneg && dmag > thr) begin
            o.root_count = qrs_pkg::COUNT_NONE;
         end else if (dmag < thr) begin
            o.root_low = scaled_quotient(!bn, bm, an, am << 1, sat);
            o.root_high = o.root_low;
            o.root_count = qrs_pkg::COUNT_ONE;
         end else begin
            s = dneg ? 0 : floor_sqrt(dmag);
            mb = bn ? $signed({2'b0, bm}) : -$signed({2'b0, bm});
            n1 = mb + $signed({2'b0, s});
            n2 = mb - $signed({2'b0, s});
            m1 = n1 < 0 ? 128'(-n1) : 128'(n1);
            m2 = n2 < 0 ? 128'(-n2) : 128'(n2);
            r1 = scaled_quotient(n1 < 0, m1, an, am << 1, sat);
            r2 = scaled_quotient(n2 < 0, m2, an, am << 1, sat);
            o.root_low = r1 < r2 ? r1 : r2;
            o.root_high = r1 < r2 ? r2 : r1;
            o.root_count = qrs_pkg::COUNT_TWO;
         end
      end
      o.saturated = sat;
      return o;
   endfunction

   assign pending = expected_roots.size();

   // predict on request, compare on result
   always @(posedge clock) begin
      qrs_pkg::rsp_type want;
      if (reset) begin
         errors <= 0;
         results_seen <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_roots.push_back(solve_roots(req_data, epsilon));
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               want = expected_roots.pop_front();
               if (want.root_count !== rsp_data.root_count ||
                   want.root_low !== rsp_data.root_low ||
                   want.root_high !== rsp_data.root_high ||
                   want.linear_case !== rsp_data.linear_case ||
                   want.saturated !== rsp_data.saturated) begin
                  $display("%0t: mismatch expected cnt=%0d lo=%h hi=%h lin=%b sat=%b",
                           $time, want.root_count, want.root_low, want.root_high,
                           want.linear_case, want.saturated);
                  $display("%0t:          actual   cnt=%0d lo=%h hi=%h lin=%b sat=%b",
                           $time, rsp_data.root_count, rsp_data.root_low,
                           rsp_data.root_high, rsp_data.linear_case, rsp_data.saturated);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

/* tb/quadratic_root_solver_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_test
// Stimulus and verdict for the quadratic root solver core.
// ----------------------------------------------------------------------------
// Sends directed and random coefficient items under several epsilon settings
// and idle patterns, including a long output hold-off that backs up the
// pipeline. Checking is done by the checker module beside the core.
module quadratic_root_solver_core_test;

   localparam int LATENCY = 93;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   qrs_pkg::req_type                  req_data;
   logic                              rsp_valid;
   logic                              rsp_stall;
   qrs_pkg::rsp_type                  rsp_data;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [qrs_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [qrs_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [qrs_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   logic [qrs_pkg::EPS_BITS-1:0] epsilon_now;
   int errors, pending, results_seen;
   int send_idle_pct, stall_pct;
   bit hold_off;
   int items_sent;

   quadratic_root_solver_core i_dut (.*);

   quadratic_root_solver_core_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .epsilon(epsilon_now), .errors, .pending, .results_seen
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

   // receiver stall, random or long hold-off
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic write_epsilon(input logic [qrs_pkg::EPS_BITS-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= qrs_pkg::CSR_EPSILON;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      epsilon_now = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // offer one item and hold it until taken
   task automatic send_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{coef_a: a, coef_b: b, coef_c: c};
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coef;
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(65535 * 4)) - 131072);
         2: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
         3: return 32'($signed($urandom_range(40)) - 20);
         4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_fff0 + $urandom_range(15);
         default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      endcase
   endfunction

   // random items; some are built from chosen roots so that discriminants land near zero
   task automatic send_random_item(input logic [qrs_pkg::EPS_BITS-1:0] eps);
      logic [31:0] a, b, c, r1, r2;
      case ($urandom_range(9))
         0, 1, 2: send_coefs(rand_coef(), rand_coef(), rand_coef());
         3, 4: begin
            a = 32'($signed($urandom_range(8)) - 4) <<< 16;
            r1 = $signed($urandom_range(16)) - 8;
            r2 = $urandom_range(1) ? r1 : $signed($urandom_range(16)) - 8;
            b = -(a * (r1 + r2));
            c = a * r1 * r2;
            send_coefs(a, b, c);
         end
         5: send_coefs(32'($urandom_range(eps + 1)) * ($urandom_range(1) ? 1 : -1),
                       rand_coef(), rand_coef());
         6: send_coefs(32'($urandom_range(eps)), 32'($urandom_range(eps + 1)),
                       32'($signed($urandom_range(2 * eps + 2)) - eps - 1));
         7: begin
            a = 32'h10000;
            b = 32'($urandom_range(4)) << 16;
            c = (b >> 1) * (b >> 1) >> 16;
            c = c + $signed($urandom_range(2 * eps + 2)) - eps - 1;
            send_coefs(a, b, c);
         end
         default: send_coefs(rand_coef(), rand_coef(), $urandom);
      endcase
   endtask

   task automatic directed_items;
      send_coefs(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);  // two roots 1 and 2
      send_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);  // double root
      send_coefs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);  // no real root
      send_coefs(32'h0000_0000, 32'h0002_0000, 32'hfffc_0000);  // linear
      send_coefs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // infinitely many
      send_coefs(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);  // none, linear
      send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
      send_coefs(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);  // clamped root
      send_coefs(32'h0000_0000, 32'h0000_0002, 32'h7fff_ffff);  // linear clamp
      send_coefs(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
      send_coefs(32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff);
      send_coefs(32'hffff_0000, 32'h0000_0000, 32'h0001_0000);  // symmetric roots
      send_coefs(32'h0000_0002, 32'h0000_0001, 32'h0000_0000);
   endtask

   task automatic random_phase(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_random_item(epsilon_now);
   endtask

   // hold results back long enough for the pipeline to fill
   task automatic pressure_phase;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b1;
      fork
         begin
            repeat (200) @(negedge clock);
            hold_off = 1'b0;
         end
         repeat (150) send_random_item(epsilon_now);
      join
   endtask

   initial begin
      logic [qrs_pkg::EPS_BITS-1:0] eps_list[5];
      eps_list = '{16'd0, 16'd1, 16'd40, 16'd65535, 16'd1000};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      items_sent = 0;
      epsilon_now = qrs_pkg::EPSILON_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset value of epsilon first
      directed_items();
      random_phase(100, 46, 46);
      drain();
      foreach (eps_list[k]) begin
         write_epsilon(eps_list[k]);
         directed_items();
         random_phase(70, 0, 0);
         random_phase(70, 46, 0);
         random_phase(70, 0, 46);
         random_phase(40, 6, 6);
         if (k == 1) pressure_phase();
         drain();
      end

      $display("sent %0d coefficient items, checked %0d results over six epsilon settings",
               items_sent, results_seen);
      $display("idle patterns and a long output hold-off were applied");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/qrs_pkg.sv
hdl/qrs_sqrt_pipe.sv
hdl/qrs_div_pipe.sv
hdl/quadratic_root_solver_core.sv
tb/quadratic_root_solver_core_checker.sv
tb/quadratic_root_solver_core_test.sv
